[sv/wlm_pkg.sv]
`timescale 1ns / 1ps

package wlm_pkg;

  // Widths of the register and stream fields.
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned DISP_W     = 8;
  localparam int unsigned REG_W      = 16;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_WINDOW_WIDTH = 8'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW_LEVEL = 8'd1;

  localparam logic [REG_W-1:0] WIDTH_RESET = 16'd65535;
  localparam logic [REG_W-1:0] LEVEL_RESET = 16'd32768;

  localparam logic [DISP_W-1:0] DISPLAY_MAX = 8'd255;

  // Working word of the divider: numerator 255 * diff with diff below 2^16.
  localparam int unsigned NUM_W = PIX_W + DISP_W;

  typedef struct packed {
    logic             zero;
    logic             sat;
    logic [PIX_W-1:0] span;
    logic [NUM_W-1:0] rem;
    logic [DISP_W-1:0] quo;
  } div_t;

endpackage

[sv/window_level_mapper_core.sv]
`timescale 1ns / 1ps
// An accepted input word passes through the registers of stages 0 to 5 to its output word.
// Throughput: one word per clock; each stage stalls only when the stage after it is full.
// The quotient is built by a restoring divider of four stages, two quotient bits each.
// Reset (rst, synchronous) empties the pipeline and sets the window to width 65535
// and level 32768.
module window_level_mapper_core
  import wlm_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]  cfg_data,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PIX_W-1:0]  s_axis_tdata,   // [15:0] pixel_in
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DISP_W-1:0] m_axis_tdata    // [7:0] display_out
);

  localparam int unsigned STAGES = 6;
  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

  logic [REG_W-1:0] window_width;
  logic [REG_W-1:0] window_level;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] ld;

  logic signed [PIX_W+1:0] s0_diff;
  logic [PIX_W-1:0]        s0_span;
  div_t                    dv [1:STAGES-2];
  logic [DISP_W-1:0]       disp;

  logic [PIX_W-1:0]        pix;
  logic [PIX_W-1:0]        half;
  logic signed [PIX_W+1:0] diff_in;
  logic [PIX_W-1:0]        span_in;
  div_t                    dv_in;
  div_t                    dv_last;

  // One restoring step: takes span << k from the remainder when it fits.
  function automatic div_t div_step(div_t a, logic [2:0] k);
    logic [NUM_W-1:0] sh;
    div_t r;
    sh = {{DISP_W{1'b0}}, a.span} << k;
    r  = a;
    if (a.rem >= sh) begin
      r.rem    = a.rem - sh;
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

  function automatic div_t div_two(div_t a, logic [2:0] top);
    return div_step(div_step(a, top), top - 3'd1);
  endfunction

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width <= WIDTH_RESET;
      window_level <= LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WINDOW_WIDTH) begin
        window_width <= cfg_data;
      end else if (cfg_index == REG_WINDOW_LEVEL) begin
        window_level <= cfg_data;
      end
    end
  end

  // Each stage may load when it is empty or when its contents move on.
  always_comb begin
    ld[STAGES-1] = !vld[STAGES-1] || m_axis_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign s_axis_tready = ld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: offset of the pixel from the bottom of the window, and the span.
  always_comb begin
    pix     = s_axis_tdata & PIX_MASK;
    half    = {1'b0, window_width[REG_W-1:1]};
    diff_in = $signed({2'b00, pix}) - $signed({2'b00, window_level})
              + $signed({2'b00, half});
    span_in = (half == '0) ? PIX_W'(1) : {half[PIX_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_diff <= diff_in;
      s0_span <= span_in;
    end
  end

  // Stage 1: clamp flags and the numerator 255 * diff.
  // When neither flag is set the offset lies below the span, so 16 bits hold it.
  always_comb begin
    dv_in.zero = (s0_diff <= 0);
    dv_in.sat  = (s0_diff >= $signed({2'b00, s0_span}));
    dv_in.span = s0_span;
    dv_in.rem  = {s0_diff[PIX_W-1:0], {DISP_W{1'b0}}}
                 - {{DISP_W{1'b0}}, s0_diff[PIX_W-1:0]};
    dv_in.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      dv[1] <= dv_in;
    end
  end

  // Stages 2 to 4: six quotient bits, most significant first.
  for (genvar i = 2; i <= STAGES - 2; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (ld[i]) begin
        dv[i] <= div_two(dv[i-1], 3'(11 - 2 * i));
      end
    end
  end

  // Stage 5: last two bits, then clamping into the output register.
  assign dv_last = div_two(dv[STAGES-2], 3'd1);

  always_ff @(posedge clk) begin
    if (ld[STAGES-1]) begin
      if (dv_last.zero) begin
        disp <= '0;
      end else if (dv_last.sat) begin
        disp <= DISPLAY_MAX;
      end else begin
        disp <= dv_last.quo;
      end
    end
  end

  assign m_axis_tvalid = vld[STAGES-1];
  assign m_axis_tdata  = disp;

  // A full pipeline held at the output must refuse new words.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while the pipeline is full and stalled");

  // An offset cannot be both at or below zero and at or above the span.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> !(dv[1].zero && dv[1].sat))
    else $error("clamp flags both set");

  // After six quotient bits the remainder stays below span << 2.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (vld[STAGES-2] && !dv[STAGES-2].zero && !dv[STAGES-2].sat)
      |-> (dv[STAGES-2].rem < ({{DISP_W{1'b0}}, dv[STAGES-2].span} << 2)))
    else $error("divider remainder out of range");

  // A stalled output word keeps its value while the rest of the pipeline waits.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(disp)))
    else $error("stalled output word changed");

endmodule
